### rtl/stun_binding_responder_defines.svh
// ---------------------------------------------------------------------------
// stun binding responder assertion macros
// concurrent checks, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef STUN_BINDING_RESPONDER_DEFINES_SVH
`define STUN_BINDING_RESPONDER_DEFINES_SVH

`ifndef SYNTHESIS
// check that holds outside reset
`define SBR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that holds at every edge, reset included
`define SBR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBR_ASSERT(label, clk, rst, prop, msg)
`define SBR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### rtl/sbr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbr_pkg
// shared types, constants and the response byte builder
// ---------------------------------------------------------------------------
package sbr_pkg;

  localparam int MaxDatagram = 2048;
  localparam int CountW      = $clog2(MaxDatagram + 1);
  localparam int HdrBytes    = 20;
  localparam int RespBytes   = 32;
  localparam int RespIdxW    = $clog2(RespBytes);
  localparam int TxnBytes    = 12;
  localparam int TxnIdxW     = $clog2(TxnBytes);
  localparam int QDepth      = 2;
  localparam int QPtrW       = $clog2(QDepth);
  localparam int QCountW     = $clog2(QDepth + 1);

  localparam logic [31:0] StunCookie  = 32'h2112A442;
  localparam logic [15:0] TypeBindReq = 16'h0001;
  localparam logic [15:0] TypeBindOk  = 16'h0101;
  localparam logic [15:0] AttrXma     = 16'h0020;

  localparam logic [2:0] REJ_OK      = 3'd0;
  localparam logic [2:0] REJ_SHORT   = 3'd1;
  localparam logic [2:0] REJ_MAGIC   = 3'd2;
  localparam logic [2:0] REJ_TYPE    = 3'd3;
  localparam logic [2:0] REJ_OVERRUN = 3'd4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] source_ip;
    logic [15:0] source_port;
  } dgram_t;

  typedef struct packed {
    logic [7:0] resp_byte;
    logic       resp_last;
    logic       accepted;
    logic [2:0] reject_code;
  } resp_t;

  // one finished datagram, handed from the parser to the response side
  typedef struct packed {
    logic [2:0]                code;
    logic [31:0]               ip;
    logic [15:0]               port;
    logic [TxnBytes-1:0][7:0]  txn;
  } job_t;

  function automatic logic [7:0] cookie_byte(input logic [1:0] sel);
    logic [7:0] r;
    unique case (sel)
      2'd0: r = StunCookie[31:24];
      2'd1: r = StunCookie[23:16];
      2'd2: r = StunCookie[15:8];
      default: r = StunCookie[7:0];
    endcase
    return r;
  endfunction

  function automatic logic [7:0] resp_byte_at(input logic [RespIdxW-1:0] idx,
                                              input job_t j);
    logic [RespIdxW-1:0] t;
    logic [15:0]         xp;
    logic [31:0]         xa;
    logic [7:0]          r;
    t  = idx - RespIdxW'(8);
    xp = j.port ^ StunCookie[31:16];
    xa = j.ip ^ StunCookie;
    unique case (idx)
      5'd0:  r = TypeBindOk[15:8];
      5'd1:  r = TypeBindOk[7:0];
      5'd2:  r = 8'd0;
      5'd3:  r = 8'(TxnBytes);
      5'd4:  r = StunCookie[31:24];
      5'd5:  r = StunCookie[23:16];
      5'd6:  r = StunCookie[15:8];
      5'd7:  r = StunCookie[7:0];
      5'd20: r = AttrXma[15:8];
      5'd21: r = AttrXma[7:0];
      5'd22: r = 8'd0;
      5'd23: r = 8'd8;
      5'd24: r = 8'd0;
      5'd25: r = 8'd1;
      5'd26: r = xp[15:8];
      5'd27: r = xp[7:0];
      5'd28: r = xa[31:24];
      5'd29: r = xa[23:16];
      5'd30: r = xa[15:8];
      5'd31: r = xa[7:0];
      default: r = j.txn[t[TxnIdxW-1:0]];
    endcase
    return r;
  endfunction

endpackage

### rtl/stun_binding_responder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stun_binding_responder
// answers stun binding requests with a binding success message
// ---------------------------------------------------------------------------
// usage:
//  dgram channel: one datagram byte per item, last_byte marks the closing
//   byte; source_ip and source_port are taken with the closing byte
//  resp channel: a valid binding request gives 32 items (the success message
//   with xor-mapped-address, resp_last on the final one); anything else gives
//   one item with resp_byte zero, accepted low and the reject code
//  throughput: one byte per cycle in, unless a closing byte is stalled; the
//   response side sends one item per cycle while the receiver does not stall
//  when the response side is idle, the closing byte's job is written into a
//   queue slot and then loaded into the output register as the first item
//  a two-job queue sits between the parser and the response side; the
//   parser stalls a closing byte only while that queue is full, middle
//   bytes are never stalled
//  receiver stall holds the output register and backs up into the queue
//  reset clears the parser, the queue and the output; no clearing pass
// ---------------------------------------------------------------------------
module stun_binding_responder import sbr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   dgram_valid,
  output logic   dgram_stall,
  input  dgram_t dgram,
  output logic   resp_valid,
  input  logic   resp_stall,
  output resp_t  resp
);

  logic push, q_full, head_valid, pop;
  job_t push_job, head_job;

  sbr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .dgram_valid (dgram_valid),
    .dgram_stall (dgram_stall),
    .dgram       (dgram),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  sbr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  sbr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .resp_valid (resp_valid),
    .resp_stall (resp_stall),
    .resp       (resp)
  );

endmodule

### rtl/sbr_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbr_front
// header parser: takes datagram bytes, checks the header, queues a job
// ---------------------------------------------------------------------------
module sbr_front import sbr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   dgram_valid,
  output logic   dgram_stall,
  input  dgram_t dgram,
  input  logic   q_full,
  output logic   push,
  output job_t   push_job
);

  logic [CountW-1:0]       byte_count, byte_count_next;
  logic [15:0]             msg_type, msg_type_next;
  logic [15:0]             msg_length, msg_length_next;
  logic                    magic_ok, magic_ok_next;
  logic [TxnBytes-1:0][7:0] txn_id_store, txn_cur;
  logic                    take, accept;
  logic [CountW-1:0]       txn_off;
  logic [2:0]              code;

  // only a closing byte needs room in the queue
  assign dgram_stall = dgram.last_byte && q_full;
  assign accept      = dgram_valid && !dgram_stall;
  assign take        = byte_count < CountW'(MaxDatagram);
  assign txn_off     = byte_count - CountW'(8);

  always_comb begin
    byte_count_next = byte_count;
    msg_type_next   = msg_type;
    msg_length_next = msg_length;
    magic_ok_next   = magic_ok;
    txn_cur         = txn_id_store;
    if (take) begin
      byte_count_next = byte_count + CountW'(1);
      if (byte_count < CountW'(2)) begin
        msg_type_next = {msg_type[7:0], dgram.data_byte};
      end else if (byte_count < CountW'(4)) begin
        msg_length_next = {msg_length[7:0], dgram.data_byte};
      end else if (byte_count < CountW'(8)) begin
        if (dgram.data_byte != cookie_byte(byte_count[1:0])) begin
          magic_ok_next = 1'b0;
        end
      end else if (byte_count < CountW'(HdrBytes)) begin
        txn_cur[txn_off[TxnIdxW-1:0]] = dgram.data_byte;
      end
    end
  end

  always_comb begin
    priority if (byte_count_next < CountW'(HdrBytes)) begin
      code = REJ_SHORT;
    end else if (!magic_ok_next) begin
      code = REJ_MAGIC;
    end else if (msg_type_next != TypeBindReq) begin
      code = REJ_TYPE;
    end else if ((17'(HdrBytes) + {1'b0, msg_length_next}) > 17'(byte_count_next)) begin
      code = REJ_OVERRUN;
    end else begin
      code = REJ_OK;
    end
  end

  assign push          = accept && dgram.last_byte;
  assign push_job.code = code;
  assign push_job.ip   = dgram.source_ip;
  assign push_job.port = dgram.source_port;
  assign push_job.txn  = txn_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      msg_type   <= '0;
      msg_length <= '0;
      magic_ok   <= 1'b1;
    end else if (accept) begin
      if (dgram.last_byte) begin
        byte_count <= '0;
        msg_type   <= '0;
        msg_length <= '0;
        magic_ok   <= 1'b1;
      end else begin
        byte_count <= byte_count_next;
        msg_type   <= msg_type_next;
        msg_length <= msg_length_next;
        magic_ok   <= magic_ok_next;
      end
    end
  end

  // transaction id bytes, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      txn_id_store <= txn_cur;
    end
  end

endmodule

### rtl/sbr_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbr_queue
// short job queue between the parser and the response side
// ---------------------------------------------------------------------------
`include "stun_binding_responder_defines.svh"
module sbr_queue import sbr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  output logic head_valid,
  output job_t head_job,
  input  logic pop
);

  job_t              slots [QDepth];
  logic [QPtrW-1:0]  wr_ptr, rd_ptr;
  logic [QCountW-1:0] count;

  assign full       = count == QCountW'(QDepth);
  assign head_valid = count != '0;
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCountW'(1);
        2'b01:   count <= count - QCountW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  `SBR_ASSERT(a_no_overflow, clk, rst, push |-> !full, "job pushed into a full queue")
  `SBR_ASSERT(a_no_underflow, clk, rst, pop |-> head_valid, "job popped from an empty queue")
  `SBR_ASSERT(a_count_bound, clk, rst, count <= QCountW'(QDepth), "queue count out of range")

endmodule

### rtl/sbr_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbr_back
// response builder: turns one job into a binding success or a reject item
// ---------------------------------------------------------------------------
`include "stun_binding_responder_defines.svh"
module sbr_back import sbr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  head_valid,
  input  job_t  head_job,
  output logic  pop,
  output logic  resp_valid,
  input  logic  resp_stall,
  output resp_t resp
);

  logic [RespIdxW-1:0] idx;
  logic                load, is_reject, at_end;
  resp_t               item;

  assign load      = head_valid && (!resp_valid || !resp_stall);
  assign is_reject = head_job.code != REJ_OK;
  assign at_end    = idx == RespIdxW'(RespBytes - 1);
  assign pop       = load && (is_reject || at_end);

  always_comb begin
    if (is_reject) begin
      item.resp_byte   = 8'd0;
      item.resp_last   = 1'b1;
      item.accepted    = 1'b0;
      item.reject_code = head_job.code;
    end else begin
      item.resp_byte   = resp_byte_at(idx, head_job);
      item.resp_last   = at_end;
      item.accepted    = 1'b1;
      item.reject_code = REJ_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
      idx        <= '0;
    end else if (load) begin
      resp_valid <= 1'b1;
      idx        <= pop ? '0 : idx + RespIdxW'(1);
    end else if (!resp_stall) begin
      resp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      resp <= item;
    end
  end

  `SBR_ASSERT(a_reject_shape, clk, rst,
    resp_valid && !resp.accepted |-> resp.resp_last && resp.reject_code != REJ_OK,
    "reject item without last flag or code")
  `SBR_ASSERT(a_accept_code, clk, rst,
    resp_valid && resp.accepted |-> resp.reject_code == REJ_OK,
    "success item carries a reject code")
  `SBR_ASSERT(a_idx_mid_job, clk, rst,
    idx != '0 |-> head_valid && head_job.code == REJ_OK,
    "response index moved without a pending success job")

endmodule

### dv/tb_stun_binding_responder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_stun_binding_responder
// self-checking bench: feeds directed and random datagrams byte by byte,
// predicts every response item and compares it field by field, with random
// idling on both sides and one long receiver hold-off to back up the block
// ---------------------------------------------------------------------------
module tb_stun_binding_responder;
  import sbr_pkg::*;

  localparam int HoldCycles   = 800;
  localparam int RandomBytes  = 136;
  localparam int DrainCycles  = 40;
  localparam int TimeLimitNs  = 8_000_000;
  localparam logic [7:0] FamilyIpv4 = 8'h01;

  typedef enum logic [2:0] {
    DG_REQUEST,
    DG_SHORT,
    DG_BAD_COOKIE,
    DG_BAD_TYPE,
    DG_OVERRUN,
    DG_NOISE
  } dg_kind_e;

  // one datagram to play; decl_len below zero means pick one to suit the kind
  typedef struct packed {
    dg_kind_e    kind;
    int          n_bytes;
    int          decl_len;
    logic [31:0] ip;
    logic [15:0] port;
    logic        typed;
    logic [2:0]  want_code;
  } dg_row_t;

  localparam dg_row_t DirectedPlan [10] = '{
    '{DG_SHORT,      1,    -1,    32'h0000_0000, 16'h0000, 1'b1, REJ_SHORT},
    '{DG_SHORT,      19,   -1,    32'hffff_ffff, 16'hffff, 1'b1, REJ_SHORT},
    '{DG_REQUEST,    20,   0,     32'h0000_0000, 16'h0000, 1'b0, REJ_OK},
    '{DG_REQUEST,    20,   0,     32'hffff_ffff, 16'hffff, 1'b0, REJ_OK},
    '{DG_REQUEST,    48,   28,    32'h2112_a442, 16'h2112, 1'b0, REJ_OK},
    '{DG_BAD_COOKIE, 20,   0,     32'hc0a8_0001, 16'h1388, 1'b1, REJ_MAGIC},
    '{DG_BAD_TYPE,   24,   4,     32'h0a00_0002, 16'h0d96, 1'b1, REJ_TYPE},
    '{DG_OVERRUN,    20,   1,     32'h7f00_0001, 16'h8000, 1'b1, REJ_OVERRUN},
    '{DG_OVERRUN,    40,   65535, 32'h8000_0000, 16'h0001, 1'b1, REJ_OVERRUN},
    '{DG_NOISE,      32,   -1,    32'h5555_aaaa, 16'ha5a5, 1'b0, REJ_OK}
  };

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   dgram_valid = 1'b0;
  logic   dgram_stall;
  dgram_t dgram = '0;
  logic   resp_valid;
  logic   resp_stall = 1'b0;
  resp_t  resp;

  // predictor state
  logic [CountW-1:0] seen_cnt = '0;
  logic [15:0]       hdr_type = '0;
  logic [15:0]       hdr_len = '0;
  logic              cookie_good = 1'b1;
  logic [7:0]        txn_copy [TxnBytes] = '{default: 8'h00};

  resp_t      reply_items [$];
  resp_t      resp_due [$];
  logic [7:0] dg_bytes [$];

  int  errors = 0;
  int  successes = 0;
  int  rej_tally [5] = '{default: 0};
  int  dgrams_played = 0;
  int  bytes_played = 0;
  bit  press_go = 1'b0;
  bit  held_done = 1'b0;

  stun_binding_responder dut (
    .clk         (clk),
    .rst         (rst),
    .dgram_valid (dgram_valid),
    .dgram_stall (dgram_stall),
    .dgram       (dgram),
    .resp_valid  (resp_valid),
    .resp_stall  (resp_stall),
    .resp        (resp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // absorbs one datagram byte and leaves the response items it causes in reply_items
  function automatic void parse_stun_byte(dgram_t d);
    logic [2:0]  code;
    logic [15:0] xp;
    logic [31:0] xa;
    logic [7:0]  msg [RespBytes];
    int          pos;
    int          k;
    reply_items.delete();
    pos = int'(seen_cnt);
    if (pos < MaxDatagram) begin
      if (pos < 2) begin
        hdr_type = {hdr_type[7:0], d.data_byte};
      end else if (pos < 4) begin
        hdr_len = {hdr_len[7:0], d.data_byte};
      end else if (pos < 8) begin
        if (d.data_byte != StunCookie[8*(7-pos) +: 8]) cookie_good = 1'b0;
      end else if (pos < HdrBytes) begin
        txn_copy[pos-8] = d.data_byte;
      end
      seen_cnt = seen_cnt + 1'b1;
    end
    if (!d.last_byte) return;

    if (int'(seen_cnt) < HdrBytes) code = REJ_SHORT;
    else if (!cookie_good) code = REJ_MAGIC;
    else if (hdr_type != TypeBindReq) code = REJ_TYPE;
    else if (HdrBytes + int'(hdr_len) > int'(seen_cnt)) code = REJ_OVERRUN;
    else code = REJ_OK;

    if (code != REJ_OK) begin
      reply_items.push_back('{8'h00, 1'b1, 1'b0, code});
    end else begin
      xp = d.source_port ^ StunCookie[31:16];
      xa = d.source_ip ^ StunCookie;
      msg[0] = TypeBindOk[15:8];
      msg[1] = TypeBindOk[7:0];
      msg[2] = 8'h00;
      msg[3] = 8'(RespBytes - HdrBytes);
      for (k = 0; k < 4; k++) msg[4+k] = StunCookie[8*(3-k) +: 8];
      for (k = 0; k < TxnBytes; k++) msg[8+k] = txn_copy[k];
      msg[20] = AttrXma[15:8];
      msg[21] = AttrXma[7:0];
      msg[22] = 8'h00;
      msg[23] = 8'h08;
      msg[24] = 8'h00;
      msg[25] = FamilyIpv4;
      msg[26] = xp[15:8];
      msg[27] = xp[7:0];
      for (k = 0; k < 4; k++) msg[28+k] = xa[8*(3-k) +: 8];
      for (k = 0; k < RespBytes; k++)
        reply_items.push_back('{msg[k], k == RespBytes - 1, 1'b1, REJ_OK});
    end
    seen_cnt    = '0;
    hdr_type    = '0;
    hdr_len     = '0;
    cookie_good = 1'b1;
  endfunction

  // builds the datagram bytes for a row and offers them one per item
  task automatic play_dgram(dg_row_t row);
    logic [7:0]  hdr [HdrBytes];
    logic [15:0] mtype;
    int          eff;
    int          decl;
    int          i;
    int          gap;
    bit          burst;
    dgram_t      d;
    eff = (row.n_bytes > MaxDatagram) ? MaxDatagram : row.n_bytes;
    if (row.decl_len >= 0) decl = row.decl_len;
    else if (row.kind == DG_REQUEST) decl = (eff >= HdrBytes) ? $urandom_range(0, eff - HdrBytes) : 0;
    else if (row.kind == DG_OVERRUN)
      decl = $urandom_range(0, 1) ? eff - HdrBytes + 1 : $urandom_range(eff - HdrBytes + 1, 65535);
    else decl = $urandom_range(0, 65535);

    mtype = TypeBindReq;
    if (row.kind == DG_BAD_TYPE) begin
      if ($urandom_range(0, 1)) mtype = TypeBindOk;
      else do mtype = 16'($urandom); while (mtype == TypeBindReq);
    end
    hdr[0] = mtype[15:8];
    hdr[1] = mtype[7:0];
    hdr[2] = decl[15:8];
    hdr[3] = decl[7:0];
    for (i = 0; i < 4; i++) hdr[4+i] = StunCookie[8*(3-i) +: 8];
    for (i = 8; i < HdrBytes; i++) hdr[i] = 8'($urandom);
    if (row.kind == DG_BAD_COOKIE) begin
      i = $urandom_range(4, 7);
      hdr[i] = hdr[i] ^ 8'($urandom_range(1, 255));
    end

    dg_bytes.delete();
    for (i = 0; i < row.n_bytes; i++)
      dg_bytes.push_back((row.kind != DG_NOISE && i < HdrBytes) ? hdr[i] : 8'($urandom));

    burst = ($urandom_range(0, 3) == 0);
    foreach (dg_bytes[j]) begin
      d.data_byte   = dg_bytes[j];
      d.last_byte   = (j == dg_bytes.size() - 1);
      d.source_ip   = d.last_byte ? row.ip : 32'($urandom);
      d.source_port = d.last_byte ? row.port : 16'($urandom);
      gap = burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        dgram_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      dgram_valid <= 1'b1;
      dgram       <= d;
      do @(posedge clk); while (dgram_stall);
      parse_stun_byte(d);
      if (d.last_byte && row.typed) resp_due.push_back('{8'h00, 1'b1, 1'b0, row.want_code});
      else foreach (reply_items[m]) resp_due.push_back(reply_items[m]);
      bytes_played++;
    end
    dgrams_played++;
  endtask

  task automatic match_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // response checker
  always @(posedge clk) begin
    resp_t want;
    if (!rst && resp_valid && !resp_stall) begin
      if (resp_due.size() == 0) begin
        $display("%0t: response item with none expected, expected nothing actual %h",
                 $time, resp);
        errors++;
      end else begin
        want = resp_due.pop_front();
        match_field("resp_byte", want.resp_byte, resp.resp_byte);
        match_field("resp_last", 8'(want.resp_last), 8'(resp.resp_last));
        match_field("accepted", 8'(want.accepted), 8'(resp.accepted));
        match_field("reject_code", 8'(want.reject_code), 8'(resp.reject_code));
        if (want.resp_last) begin
          if (want.accepted) successes++;
          else rej_tally[want.reject_code]++;
        end
      end
    end
  end

  // receiver: random waits per item, calm stretches, one long hold-off
  initial begin : resp_drain
    int  wait_cyc;
    int  held;
    int  n_taken;
    bit  calm;
    n_taken = 0;
    calm    = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (press_go && !held_done) begin
        resp_stall <= 1'b1;
        for (held = 0; held < HoldCycles; held++) @(posedge clk);
        held_done = 1'b1;
      end
      if (n_taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      wait_cyc = calm ? 0 : $urandom_range(0, 13);
      if (wait_cyc > 0) begin
        resp_stall <= 1'b1;
        repeat (wait_cyc) @(posedge clk);
      end
      resp_stall <= 1'b0;
      do @(posedge clk); while (!resp_valid);
      n_taken++;
    end
  end

  initial begin : stimulus
    dg_row_t row;
    int      pick;
    int      n_rand;
    int      start_bytes;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DirectedPlan[i]) play_dgram(DirectedPlan[i]);

    // random part: mostly well-formed requests, the rest broken or noise
    press_go    = 1'b1;
    n_rand      = 0;
    start_bytes = bytes_played;
    while (bytes_played - start_bytes < RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) row.kind = DG_REQUEST;
      else if (pick < 65) row.kind = DG_SHORT;
      else if (pick < 75) row.kind = DG_BAD_COOKIE;
      else if (pick < 85) row.kind = DG_BAD_TYPE;
      else if (pick < 95) row.kind = DG_OVERRUN;
      else row.kind = DG_NOISE;
      // short ones first so the hold-off fills the job queue
      if (row.kind == DG_SHORT) row.n_bytes = $urandom_range(1, HdrBytes - 1);
      else if (n_rand < 10) row.n_bytes = $urandom_range(HdrBytes, HdrBytes + 4);
      else if ($urandom_range(0, 9) == 0) row.n_bytes = $urandom_range(HdrBytes, 120);
      else row.n_bytes = $urandom_range(HdrBytes, 40);
      row.decl_len  = -1;
      row.ip        = $urandom;
      row.port      = 16'($urandom);
      row.typed     = 1'b0;
      row.want_code = REJ_OK;
      play_dgram(row);
      n_rand++;
    end
    dgram_valid <= 1'b0;

    while (resp_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("played %0d datagrams (%0d bytes) with idling and a long receiver hold-off",
             dgrams_played, bytes_played);
    $display("binding successes %0d, rejects short/magic/type/overrun %0d/%0d/%0d/%0d",
             successes, rej_tally[REJ_SHORT], rej_tally[REJ_MAGIC], rej_tally[REJ_TYPE],
             rej_tally[REJ_OVERRUN]);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeLimitNs);
    $display("timeout with %0d response items outstanding", resp_due.size());
    $display("simulation failed");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/sbr_pkg.sv
rtl/sbr_front.sv
rtl/sbr_queue.sv
rtl/sbr_back.sv
rtl/stun_binding_responder.sv
dv/tb_stun_binding_responder.sv
